### rtl/kms_pkg.sv
// ----------------------------------------------------------------------------
// kms_pkg
// Shared types, codes and helpers of the keyed multi-stack manager.
// ----------------------------------------------------------------------------
package kms_pkg;

    localparam int NUM_STACKS_DEF  = 8;
    localparam int STACK_DEPTH_DEF = 64;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [2:0] CMD_CREATE = 3'd0;
    localparam logic [2:0] CMD_PUSH   = 3'd1;
    localparam logic [2:0] CMD_POP    = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_INFO   = 3'd4;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_EXISTS   = 3'd1;
    localparam logic [2:0] STAT_NOFREE   = 3'd2;
    localparam logic [2:0] STAT_NOTFOUND = 3'd3;
    localparam logic [2:0] STAT_EMPTY    = 3'd4;
    localparam logic [2:0] STAT_FULL     = 3'd5;

    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_WORD  = 2'd1;
    localparam logic [1:0] SIZE_DWORD = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [30:0] key;
        logic [1:0]  element_size;
        logic [6:0]  capacity;
        logic [63:0] push_value;
    } req_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot_index;
        logic [63:0] pop_value;
        logic [1:0]  size_out;
        logic [6:0]  count_out;
        logic [6:0]  capacity_out;
    } rsp_word_t;

    // queued word plus the front's verdict on it
    typedef struct packed {
        req_word_t word;
        logic      bad;
    } q_item_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_MATCH,
        BS_RESOLVE,
        BS_POPWAIT
    } back_state_t;

    function automatic logic [63:0] size_mask(input logic [1:0] code);
        logic [63:0] m;
        case (code)
            SIZE_BYTE: m = 64'h0000_0000_0000_00FF;
            SIZE_WORD: m = 64'h0000_0000_FFFF_FFFF;
            default:   m = '1;
        endcase
        return m;
    endfunction

endpackage

### rtl/keyed_multi_stack_manager_top.sv
// ----------------------------------------------------------------------------
// keyed_multi_stack_manager_top
// Keyed stack manager: descriptor slots plus a shared element store.
// ----------------------------------------------------------------------------
// A command word is taken on request at a clock edge with start high and busy
// low. busy rises only when the two-entry command queue is full. Each word
// gives exactly one response word, shown on response for one cycle with done
// high; the receiver cannot hold it off and must take it then.
// From accept to done a word passes the queue write, key match and resolve;
// a pop that returns an element also waits on the element store's registered
// read. The back end takes the next word only as the current one is answered:
// key match compares the key against all slots, resolve picks the slot and
// updates the descriptor and the store port. The queue absorbs bursts.
// Reset clears the queue, the state and all descriptor slots at once; the
// element store is not cleared, since a pop only reads entries pushed since
// the slot was created.
// ----------------------------------------------------------------------------
module keyed_multi_stack_manager_top #(
    parameter int NUM_STACKS  = kms_pkg::NUM_STACKS_DEF,
    parameter int STACK_DEPTH = kms_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  kms_pkg::req_word_t request,
    output logic               busy,
    output logic               done,
    output kms_pkg::rsp_word_t response
);

    logic             q_valid;
    logic             q_pop;
    kms_pkg::q_item_t q_item;

    kms_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    kms_back #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .done     (done),
        .response (response)
    );

endmodule

### rtl/kms_ram.sv
// ----------------------------------------------------------------------------
// kms_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module kms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/kms_front.sv
// ----------------------------------------------------------------------------
// kms_front
// Accepts command words, flags bad keys and codes, and queues them.
// ----------------------------------------------------------------------------
module kms_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  kms_pkg::req_word_t request,
    output logic               busy,
    output logic               q_valid,
    output kms_pkg::q_item_t   q_item,
    input  logic               q_pop
);

    kms_pkg::q_item_t             entry_reg [kms_pkg::QDEPTH];
    logic [kms_pkg::QPW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [kms_pkg::QPW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [kms_pkg::QCW-1:0]      fill_reg, fill_next;
    kms_pkg::q_item_t             incoming;
    logic                         push;

    assign busy    = (fill_reg == kms_pkg::QCW'(kms_pkg::QDEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = start && !busy;

    always_comb
    begin
        incoming.word = request;
        // key zero and unknown commands answer not found, whatever the key match gives
        incoming.bad  = (request.key == '0) || (request.command > kms_pkg::CMD_INFO);

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == kms_pkg::QPW'(kms_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop && q_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == kms_pkg::QPW'(kms_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !(q_pop && q_valid))
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && q_pop && q_valid)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

### rtl/kms_back.sv
// ----------------------------------------------------------------------------
// kms_back
// Descriptor table, key match and element store access; one response a word.
// ----------------------------------------------------------------------------
module kms_back #(
    parameter int NUM_STACKS  = kms_pkg::NUM_STACKS_DEF,
    parameter int STACK_DEPTH = kms_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  kms_pkg::q_item_t   q_item,
    output logic               q_pop,
    output logic               done,
    output kms_pkg::rsp_word_t response
);

    localparam int SW        = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int MEM_DEPTH = NUM_STACKS * STACK_DEPTH;
    localparam int MAW       = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CAP_CLAMP = (STACK_DEPTH > 127) ? 127 : STACK_DEPTH;

    kms_pkg::back_state_t state_reg, state_next;

    logic [30:0] key_reg   [NUM_STACKS];
    logic [30:0] key_next  [NUM_STACKS];
    logic        used_reg  [NUM_STACKS];
    logic        used_next [NUM_STACKS];
    logic [1:0]  size_reg  [NUM_STACKS];
    logic [1:0]  size_next [NUM_STACKS];
    logic [6:0]  cap_reg   [NUM_STACKS];
    logic [6:0]  cap_next  [NUM_STACKS];
    logic [6:0]  cnt_reg   [NUM_STACKS];
    logic [6:0]  cnt_next  [NUM_STACKS];

    kms_pkg::q_item_t   item_reg, item_next;
    logic [NUM_STACKS-1:0] hit_reg, hit_next;
    logic [NUM_STACKS-1:0] free_reg, free_next;
    kms_pkg::rsp_word_t resp_reg, resp_next;
    logic               done_reg, done_next;

    logic               hit_found, free_found;
    logic [SW-1:0]      hit_idx, free_idx;
    logic [1:0]         new_size;
    logic [6:0]         new_cap;
    logic               finish, to_popwait;

    logic               ram_we;
    logic [MAW-1:0]     ram_addr;
    logic [63:0]        ram_wdata, ram_rdata;

    kms_ram #(
        .WIDTH (64),
        .DEPTH (MEM_DEPTH),
        .AW    (MAW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign done     = done_reg;
    assign response = resp_reg;

    // lowest set bit wins
    always_comb
    begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        for (int i = NUM_STACKS - 1; i >= 0; i--)
        begin
            if (hit_reg[i])
            begin
                hit_found = 1'b1;
                hit_idx   = SW'(i);
            end
            if (free_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    always_comb
    begin
        new_size = (item_reg.word.element_size == 2'd3) ? kms_pkg::SIZE_DWORD :
                   item_reg.word.element_size;
        new_cap  = (item_reg.word.capacity > 7'(CAP_CLAMP)) ? 7'(CAP_CLAMP) :
                   item_reg.word.capacity;
    end

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        used_next  = used_reg;
        size_next  = size_reg;
        cap_next   = cap_reg;
        cnt_next   = cnt_reg;
        item_next  = item_reg;
        hit_next   = hit_reg;
        free_next  = free_reg;
        resp_next  = resp_reg;
        done_next  = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = '0;
        ram_wdata  = '0;
        to_popwait = 1'b0;
        finish     = 1'b0;

        case (state_reg)
            kms_pkg::BS_MATCH:
            begin
                for (int i = 0; i < NUM_STACKS; i++)
                begin
                    hit_next[i]  = used_reg[i] && (key_reg[i] == item_reg.word.key);
                    free_next[i] = !used_reg[i];
                end
                state_next = kms_pkg::BS_RESOLVE;
            end

            kms_pkg::BS_RESOLVE:
            begin
                resp_next        = '0;
                resp_next.status = kms_pkg::STAT_NOTFOUND;
                done_next        = 1'b1;
                finish           = 1'b1;
                if (!item_reg.bad)
                begin
                    case (item_reg.word.command)
                        kms_pkg::CMD_CREATE:
                        begin
                            if (hit_found)
                            begin
                                resp_next.status       = kms_pkg::STAT_EXISTS;
                                resp_next.slot_index   = 3'(hit_idx);
                                resp_next.size_out     = size_reg[hit_idx];
                                resp_next.count_out    = cnt_reg[hit_idx];
                                resp_next.capacity_out = cap_reg[hit_idx];
                            end
                            else if (!free_found)
                            begin
                                resp_next.status = kms_pkg::STAT_NOFREE;
                            end
                            else
                            begin
                                used_next[free_idx]    = 1'b1;
                                key_next[free_idx]     = item_reg.word.key;
                                size_next[free_idx]    = new_size;
                                cap_next[free_idx]     = new_cap;
                                cnt_next[free_idx]     = '0;
                                resp_next.status       = kms_pkg::STAT_OK;
                                resp_next.slot_index   = 3'(free_idx);
                                resp_next.size_out     = new_size;
                                resp_next.capacity_out = new_cap;
                            end
                        end

                        kms_pkg::CMD_PUSH:
                        begin
                            if (hit_found)
                            begin
                                resp_next.slot_index   = 3'(hit_idx);
                                resp_next.size_out     = size_reg[hit_idx];
                                resp_next.capacity_out = cap_reg[hit_idx];
                                resp_next.count_out    = cnt_reg[hit_idx];
                                // capacity is already clamped to the region size
                                if (cnt_reg[hit_idx] >= cap_reg[hit_idx])
                                begin
                                    resp_next.status = kms_pkg::STAT_FULL;
                                end
                                else
                                begin
                                    ram_we    = 1'b1;
                                    ram_addr  = MAW'(hit_idx) * MAW'(STACK_DEPTH) +
                                                MAW'(cnt_reg[hit_idx]);
                                    ram_wdata = item_reg.word.push_value &
                                                kms_pkg::size_mask(size_reg[hit_idx]);
                                    cnt_next[hit_idx]   = cnt_reg[hit_idx] + 7'd1;
                                    resp_next.count_out = cnt_reg[hit_idx] + 7'd1;
                                    resp_next.status    = kms_pkg::STAT_OK;
                                end
                            end
                        end

                        kms_pkg::CMD_POP:
                        begin
                            if (hit_found)
                            begin
                                resp_next.slot_index   = 3'(hit_idx);
                                resp_next.size_out     = size_reg[hit_idx];
                                resp_next.capacity_out = cap_reg[hit_idx];
                                resp_next.count_out    = cnt_reg[hit_idx];
                                if (cnt_reg[hit_idx] == '0)
                                begin
                                    resp_next.status = kms_pkg::STAT_EMPTY;
                                end
                                else
                                begin
                                    ram_addr = MAW'(hit_idx) * MAW'(STACK_DEPTH) +
                                               MAW'(cnt_reg[hit_idx] - 7'd1);
                                    cnt_next[hit_idx]   = cnt_reg[hit_idx] - 7'd1;
                                    resp_next.count_out = cnt_reg[hit_idx] - 7'd1;
                                    resp_next.status    = kms_pkg::STAT_OK;
                                    // element comes back from the store next cycle
                                    done_next  = 1'b0;
                                    finish     = 1'b0;
                                    to_popwait = 1'b1;
                                end
                            end
                        end

                        kms_pkg::CMD_REMOVE:
                        begin
                            if (hit_found)
                            begin
                                used_next[hit_idx]   = 1'b0;
                                key_next[hit_idx]    = '0;
                                size_next[hit_idx]   = '0;
                                cap_next[hit_idx]    = '0;
                                cnt_next[hit_idx]    = '0;
                                resp_next.status     = kms_pkg::STAT_OK;
                                resp_next.slot_index = 3'(hit_idx);
                            end
                        end

                        kms_pkg::CMD_INFO:
                        begin
                            if (hit_found)
                            begin
                                resp_next.status       = kms_pkg::STAT_OK;
                                resp_next.slot_index   = 3'(hit_idx);
                                resp_next.size_out     = size_reg[hit_idx];
                                resp_next.count_out    = cnt_reg[hit_idx];
                                resp_next.capacity_out = cap_reg[hit_idx];
                            end
                        end

                        default:
                        begin
                            resp_next.status = kms_pkg::STAT_NOTFOUND;
                        end
                    endcase
                end
                if (to_popwait)
                begin
                    state_next = kms_pkg::BS_POPWAIT;
                end
                else
                begin
                    state_next = kms_pkg::BS_IDLE;
                end
            end

            kms_pkg::BS_POPWAIT:
            begin
                resp_next.pop_value = ram_rdata & kms_pkg::size_mask(resp_reg.size_out);
                done_next  = 1'b1;
                finish     = 1'b1;
                state_next = kms_pkg::BS_IDLE;
            end

            default:
            begin
                state_next = kms_pkg::BS_IDLE;
            end
        endcase

        // take the next queued word as soon as the current one is answered
        q_pop = q_valid && ((state_reg == kms_pkg::BS_IDLE) || finish);
        if (q_pop)
        begin
            item_next  = q_item;
            state_next = kms_pkg::BS_MATCH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kms_pkg::BS_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                key_reg[i]  <= '0;
                used_reg[i] <= 1'b0;
                size_reg[i] <= '0;
                cap_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            key_reg   <= key_next;
            used_reg  <= used_next;
            size_reg  <= size_next;
            cap_reg   <= cap_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        hit_reg  <= hit_next;
        free_reg <= free_next;
        resp_reg <= resp_next;
    end

endmodule
